// ===== sv/ocpb_pkg.sv =====
// Package for the command packet builder: entry type, frame constants,
// mask table lookup and the CRC-16 byte step. No dependencies.
`default_nettype none

package ocpb_pkg;

  // Frame layout.
  localparam int FRAME_LEN   = 26;
  localparam int HEADER_LEN  = 4;
  localparam int BODY_LEN    = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [4:0] POS_BODY_FIRST = 5'd4;
  localparam logic [4:0] POS_BODY_LAST  = 5'd19;
  localparam logic [4:0] POS_LAST       = 5'd25;

  // Body positions with a special role.
  localparam logic [3:0] BI_INNER_FIRST = 4'd9;
  localparam logic [3:0] BI_INNER_LAST  = 4'd13;
  localparam logic [3:0] BI_CRC_LAST    = 4'd12;
  localparam logic [3:0] BI_CRC_LOW     = 4'd14;
  localparam logic [3:0] BI_CRC_HIGH    = 4'd15;

  // Fixed byte values.
  localparam logic [7:0]  SKIP_CMD   = 8'hB4;
  localparam logic [7:0]  OUTER_KEY  = 8'h56;
  localparam logic [7:0]  FILL_BYTE  = 8'hFF;
  localparam logic [7:0]  HDR_BYTE0  = 8'h48;
  localparam logic [7:0]  HDR_BYTE1  = 8'h46;
  localparam logic [7:0]  HDR_BYTE2  = 8'h4B;
  localparam logic [7:0]  HDR_BYTE3  = 8'h4A;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'h0000;

  // Configuration register indexes.
  localparam logic [1:0] REG_SBOX_LOW  = 2'd0;
  localparam logic [1:0] REG_SBOX_HIGH = 2'd1;

  // One classified command as it waits in the queue.
  typedef struct packed {
    logic [7:0]  seq_id;
    logic [31:0] device_address;
    logic [7:0]  command;
    logic [7:0]  seq_num;
    logic [7:0]  rnd;
    logic [7:0]  payload_first;
    logic [7:0]  payload_second;
    logic [7:0]  payload_third;
    logic        skip_inner;
    logic [3:0]  km_inner_idx;
    logic [3:0]  km_outer_idx;
  } entry_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Read one entry of the 16-entry mask table.
  function automatic logic [7:0] table_entry(input logic [63:0] lo,
                                             input logic [63:0] hi,
                                             input logic [3:0]  idx);
    logic [63:0] word;
    word = idx[3] ? hi : lo;
    return word[{idx[2:0], 3'b000} +: 8];
  endfunction

  // One byte of CRC-16, polynomial 0x1021, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                           input logic [7:0]  d);
    logic [15:0] c;
    c = crc ^ {d, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ocpb_front.sv =====
// Front end: accepts commands and classifies them into queue entries.
// Depends on ocpb_pkg.
`default_nettype none

module ocpb_front (
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [7:0]         seq_id,
  input  wire logic [31:0]        device_address,
  input  wire logic [7:0]         command,
  input  wire logic [7:0]         seq_num,
  input  wire logic [7:0]         payload_first,
  input  wire logic [7:0]         payload_second,
  input  wire logic [7:0]         payload_third,
  input  wire ocpb_pkg::q_status_t q_status,
  output logic                    push,
  output ocpb_pkg::entry_t        push_entry
);
  import ocpb_pkg::*;

  logic [7:0] rnd;

  // A word is taken whenever the queue has room.
  assign busy = q_status.full;
  assign push = start && !q_status.full;

  // Classify the command and work out the mask key indexes.
  assign rnd = seq_num + 8'd1;

  always_comb begin
    push_entry.seq_id         = seq_id;
    push_entry.device_address = device_address;
    push_entry.command        = command;
    push_entry.seq_num        = seq_num;
    push_entry.rnd            = rnd;
    push_entry.payload_first  = payload_first;
    push_entry.payload_second = payload_second;
    push_entry.payload_third  = payload_third;
    push_entry.skip_inner     = (command == SKIP_CMD);
    push_entry.km_inner_idx   = seq_num[7:4] ^ seq_num[3:0];
    push_entry.km_outer_idx   = rnd[7:4] ^ rnd[3:0];
  end

endmodule

`default_nettype wire

// ===== sv/ocpb_queue.sv =====
// Short queue of classified commands between the front and back ends.
// Depends on ocpb_pkg.
`default_nettype none

module ocpb_queue #(
  parameter int DEPTH = ocpb_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire ocpb_pkg::entry_t   push_entry,
  input  wire logic               pop,
  output ocpb_pkg::entry_t        head,
  output ocpb_pkg::q_status_t     q_status
);
  import ocpb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign q_status.full  = (count == CNT_FULL);
  assign q_status.empty = (count == '0);
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign head    = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/ocpb_back.sv =====
// Back end: walks the head command through its 26 frame positions,
// masking, running the CRC and registering one byte a cycle while active.
// Depends on ocpb_pkg.
`default_nettype none

module ocpb_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [63:0]        sbox_low,
  input  wire logic [63:0]        sbox_high,
  input  wire ocpb_pkg::entry_t   head,
  input  wire ocpb_pkg::q_status_t q_status,
  output logic                    pop,
  output logic [7:0]              frame_byte,
  output logic                    last_byte,
  output logic                    strobe
);
  import ocpb_pkg::*;

  logic [4:0]  pos;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic        active;
  logic [4:0]  bi_wide;
  logic [3:0]  bi;
  logic        in_body;
  logic [7:0]  raw;
  logic [7:0]  inner;
  logic [7:0]  outer;
  logic [7:0]  byte_next;
  logic [7:0]  km_inner;
  logic [7:0]  km_outer;
  logic [3:0]  inner_idx;
  logic [3:0]  outer_idx;

  assign active  = !q_status.empty;
  assign pop     = active && (pos == POS_LAST);
  assign bi_wide = pos - POS_BODY_FIRST;
  assign bi      = bi_wide[3:0];
  assign in_body = (pos >= POS_BODY_FIRST) && (pos <= POS_BODY_LAST);

  // Raw body byte at this position.
  always_comb begin
    case (bi)
      4'd1:        raw = head.rnd;
      4'd2:        raw = head.seq_num;
      4'd3:        raw = head.device_address[7:0];
      4'd4:        raw = head.device_address[15:8];
      4'd5:        raw = head.device_address[23:16];
      4'd6:        raw = head.device_address[31:24];
      4'd7:        raw = head.command;
      4'd10:       raw = head.seq_num;
      4'd11:       raw = head.payload_first;
      4'd12:       raw = head.payload_second;
      4'd13:       raw = head.payload_third;
      BI_CRC_LOW:  raw = crc[7:0];
      BI_CRC_HIGH: raw = crc[15:8];
      default:     raw = FILL_BYTE;
    endcase
  end

  // Inner masking over body bytes 9 to 13 unless the command skips it.
  assign km_inner  = table_entry(sbox_low, sbox_high, head.km_inner_idx);
  assign inner_idx = (bi - BI_INNER_FIRST) + head.seq_id[3:0];

  always_comb begin
    if (!head.skip_inner && (bi >= BI_INNER_FIRST) && (bi <= BI_INNER_LAST)) begin
      inner = (raw ^ km_inner) + table_entry(sbox_low, sbox_high, inner_idx);
    end else begin
      inner = raw;
    end
  end

  // CRC runs over the inner-masked bytes 0 to 12; it restarts at byte 0.
  always_comb begin
    crc_next = crc;
    if (in_body && (bi <= BI_CRC_LAST)) begin
      crc_next = crc_byte((bi == 4'd0) ? CRC_INIT : crc, inner);
    end
  end

  // Outer masking over the whole body.
  assign km_outer  = table_entry(sbox_low, sbox_high, head.km_outer_idx);
  assign outer_idx = bi + OUTER_KEY[3:0];
  assign outer     = (inner ^ km_outer) + table_entry(sbox_low, sbox_high, outer_idx);

  // Frame byte: header, masked body, then fill.
  always_comb begin
    if (pos == 5'd0) begin
      byte_next = HDR_BYTE0;
    end else if (pos == 5'd1) begin
      byte_next = HDR_BYTE1;
    end else if (pos == 5'd2) begin
      byte_next = HDR_BYTE2;
    end else if (pos == 5'd3) begin
      byte_next = HDR_BYTE3;
    end else if (in_body) begin
      byte_next = outer;
    end else begin
      byte_next = FILL_BYTE;
    end
  end

  // Position counter, CRC and output strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      crc       <= CRC_INIT;
      strobe    <= 1'b0;
      last_byte <= 1'b0;
    end else begin
      strobe    <= active;
      last_byte <= active && (pos == POS_LAST);
      if (active) begin
        crc <= crc_next;
        pos <= (pos == POS_LAST) ? '0 : pos + 5'd1;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    frame_byte <= byte_next;
  end

  // A frame, once started, always has its command at the head.
  a_mid_frame_has_head: assert property (@(posedge clk) disable iff (rst)
    (pos != 5'd0) |-> !q_status.empty)
    else $error("frame in progress with an empty queue");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_LAST)
    else $error("frame position out of range");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    pop |=> (pos == 5'd0) && strobe && last_byte)
    else $error("last word did not close the frame");

  a_last_needs_strobe: assert property (@(posedge clk) disable iff (rst)
    last_byte |-> strobe)
    else $error("last flag without a word");

endmodule

`default_nettype wire

// ===== sv/obfuscated_command_packet_builder.sv =====
// Top level of the command packet builder: configuration registers,
// front end, command queue and back end. Depends on ocpb_pkg and its modules.
//
// Usage:
//   Command channel: a command word is taken at a rising edge with start high
//   and busy low. busy rises only when the command queue (QUEUE_DEPTH
//   entries) is full.
//   Result channel: each accepted command gives 26 frame words, one per cycle,
//   on frame_byte with strobe high; last_byte marks the 26th. When the back
//   end is free, the first word follows once the command is written into the
//   queue and the back end has registered it onto frame_byte and strobe.
//   The back end emits one frame byte per cycle from its single position
//   counter, taking a new command only after the previous frame's last byte.
//   Commands queued behind one another give a gapless stream of frames.
//   Configuration: cfg_we writes cfg_data into sbox_low (index 0) or
//   sbox_high (index 1); other indexes are ignored. Write only while idle.
//   Reset (rst, synchronous): empties the queue, clears the frame counter
//   and both table registers. The receiver cannot stall; every strobed word
//   must be taken in its cycle.
`default_nettype none

module obfuscated_command_packet_builder #(
  parameter int QUEUE_DEPTH = ocpb_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  seq_id,
  input  wire logic [31:0] device_address,
  input  wire logic [7:0]  command,
  input  wire logic [7:0]  seq_num,
  input  wire logic [7:0]  payload_first,
  input  wire logic [7:0]  payload_second,
  input  wire logic [7:0]  payload_third,
  output logic [7:0]       frame_byte,
  output logic             last_byte,
  output logic             strobe,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import ocpb_pkg::*;

  logic [63:0] sbox_low;
  logic [63:0] sbox_high;
  q_status_t   q_status;
  entry_t      push_entry;
  entry_t      head;
  logic        push;
  logic        pop;

  // Mask table registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sbox_low  <= '0;
      sbox_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SBOX_LOW:  sbox_low  <= cfg_data;
        REG_SBOX_HIGH: sbox_high <= cfg_data;
        default: ;
      endcase
    end
  end

  ocpb_front u_front (
    .start          (start),
    .busy           (busy),
    .seq_id         (seq_id),
    .device_address (device_address),
    .command        (command),
    .seq_num        (seq_num),
    .payload_first  (payload_first),
    .payload_second (payload_second),
    .payload_third  (payload_third),
    .q_status       (q_status),
    .push           (push),
    .push_entry     (push_entry)
  );

  ocpb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  ocpb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .sbox_low   (sbox_low),
    .sbox_high  (sbox_high),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .strobe     (strobe)
  );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for obfuscated_command_packet_builder: drives command words,
// predicts each 26-word frame and checks every strobed frame word in order.
// Depends on ocpb_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
  import ocpb_pkg::*;

  // Register indexes the block has no register behind; writes there are ignored.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [7:0]  seq_id;
    logic [31:0] address;
    logic [7:0]  opcode;
    logic [7:0]  seq_num;
    logic [7:0]  pay0;
    logic [7:0]  pay1;
    logic [7:0]  pay2;
  } cmd_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  seq_id = '0;
  logic [31:0] device_address = '0;
  logic [7:0]  command = '0;
  logic [7:0]  seq_num = '0;
  logic [7:0]  payload_first = '0;
  logic [7:0]  payload_second = '0;
  logic [7:0]  payload_third = '0;
  logic [7:0]  frame_byte;
  logic        last_byte;
  logic        strobe;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // Shadow copy of the mask table registers.
  logic [63:0] table_low = '0;
  logic [63:0] table_high = '0;

  cmd_t        pending_cmds[$];
  frame_word_t frame_words_due[$];
  int          cmds_outstanding = 0;
  int          fault_count = 0;
  int          gap_left = 0;
  bit          gaps_enabled = 1'b1;

  obfuscated_command_packet_builder dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .seq_id         (seq_id),
    .device_address (device_address),
    .command        (command),
    .seq_num        (seq_num),
    .payload_first  (payload_first),
    .payload_second (payload_second),
    .payload_third  (payload_third),
    .frame_byte     (frame_byte),
    .last_byte      (last_byte),
    .strobe         (strobe),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Entry of the 16-entry mask table held in the shadow registers.
  function automatic logic [7:0] sbox_at(input logic [3:0] idx);
    logic [127:0] both;
    both = {table_high, table_low};
    return both[{idx, 3'b000} +: 8];
  endfunction

  // Masks a run of body bytes; the key mask comes from the modifier's two nibbles.
  function automatic logic [15:0][7:0] scramble_run(input logic [15:0][7:0] body,
                                                   input int first, input int count,
                                                   input logic [7:0] key_offset,
                                                   input logic [7:0] modifier);
    logic [7:0] km;
    logic [3:0] k;
    km = sbox_at(modifier[7:4] ^ modifier[3:0]);
    for (int i = 0; i < count; i++) begin
      if (first + i < BODY_LEN) begin
        k = key_offset[3:0] + i[3:0];
        body[first + i] = (body[first + i] ^ km) + sbox_at(k);
      end
    end
    return body;
  endfunction

  // CRC-16 with polynomial 0x1021 and zero start, most significant bit first.
  function automatic logic [15:0] crc16_over(input logic [15:0][7:0] body, input int n);
    logic [15:0] r;
    r = 16'h0000;
    for (int i = 0; i < n; i++) begin
      r = r ^ {body[i], 8'h00};
      for (int b = 0; b < 8; b++) begin
        r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
      end
    end
    return r;
  endfunction

  // Whole 26-word frame that one command should produce.
  function automatic logic [25:0][7:0] build_frame(input cmd_t c);
    logic [15:0][7:0] body;
    logic [25:0][7:0] f;
    logic [15:0]      crc;
    logic [7:0]       rnd;
    rnd = c.seq_num + 8'd1;
    body[0]  = FILL_BYTE;
    body[1]  = rnd;
    body[2]  = c.seq_num;
    body[3]  = c.address[7:0];
    body[4]  = c.address[15:8];
    body[5]  = c.address[23:16];
    body[6]  = c.address[31:24];
    body[7]  = c.opcode;
    body[8]  = FILL_BYTE;
    body[9]  = FILL_BYTE;
    body[10] = c.seq_num;
    body[11] = c.pay0;
    body[12] = c.pay1;
    body[13] = c.pay2;
    body[14] = 8'h00;
    body[15] = 8'h00;
    if (c.opcode != SKIP_CMD) begin
      body = scramble_run(body, 9, 5, c.seq_id, c.seq_num);
    end
    crc = crc16_over(body, 13);
    body[14] = crc[7:0];
    body[15] = crc[15:8];
    body = scramble_run(body, 0, BODY_LEN, OUTER_KEY, rnd);
    f[0] = HDR_BYTE0;
    f[1] = HDR_BYTE1;
    f[2] = HDR_BYTE2;
    f[3] = HDR_BYTE3;
    for (int k = 0; k < BODY_LEN; k++) f[HEADER_LEN + k] = body[k];
    for (int k = HEADER_LEN + BODY_LEN; k < FRAME_LEN; k++) f[k] = FILL_BYTE;
    return f;
  endfunction

  task automatic push_cmd(input logic [7:0] sid, input logic [31:0] addr,
                          input logic [7:0] op, input logic [7:0] sn,
                          input logic [7:0] p0, input logic [7:0] p1,
                          input logic [7:0] p2);
    cmd_t c;
    c = '{seq_id: sid, address: addr, opcode: op, seq_num: sn,
          pay0: p0, pay1: p1, pay2: p2};
    pending_cmds.push_back(c);
    cmds_outstanding++;
  endtask

  task automatic push_random_cmd();
    logic [7:0] op;
    op = ($urandom_range(0, 3) == 0) ? SKIP_CMD : 8'($urandom);
    push_cmd(8'($urandom), $urandom, op, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom));
  endtask

  // Register write; only ever issued while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SBOX_LOW) table_low = value;
    else if (idx == REG_SBOX_HIGH) table_high = value;
  endtask

  // Waits until every command is taken and every frame word has arrived.
  task automatic drain_all();
    while (cmds_outstanding != 0 || frame_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: presents queued commands, with a random gap after each one when gaps are enabled.
  always @(posedge clk) begin
    cmd_t        next_cmd;
    cmd_t        taken;
    logic [25:0][7:0] f;
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else if (!(start && busy)) begin
      if (start) begin
        // The command word on the ports has just been accepted.
        taken = '{seq_id: seq_id, address: device_address, opcode: command,
                  seq_num: seq_num, pay0: payload_first, pay1: payload_second,
                  pay2: payload_third};
        f = build_frame(taken);
        for (int k = 0; k < FRAME_LEN; k++) begin
          frame_words_due.push_back('{value: f[k], last: (k == FRAME_LEN - 1)});
        end
        cmds_outstanding--;
      end
      if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() != 0) begin
        next_cmd = pending_cmds.pop_front();
        seq_id         <= next_cmd.seq_id;
        device_address <= next_cmd.address;
        command        <= next_cmd.opcode;
        seq_num        <= next_cmd.seq_num;
        payload_first  <= next_cmd.pay0;
        payload_second <= next_cmd.pay1;
        payload_third  <= next_cmd.pay2;
        start          <= 1'b1;
        gap_left       <= gaps_enabled ? int'($urandom_range(0, 3)) : 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed word is compared with the oldest expected word.
  always @(posedge clk) begin
    frame_word_t want;
    if (!rst && strobe) begin
      if (frame_words_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: unexpected frame word %h last %b", $time, frame_byte, last_byte);
      end else begin
        want = frame_words_due.pop_front();
        if (frame_byte !== want.value || last_byte !== want.last) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: frame word mismatch: expected %h last %b, got %h last %b",
                     $time, want.value, want.last, frame_byte, last_byte);
        end
      end
    end
  end

  // Stimulus in phases; table registers change only between phases.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Tables still at reset: the masking leaves the body unchanged.
    push_cmd(8'h00, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(8'hFF, 32'hFFFF_FFFF, SKIP_CMD, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(8'($urandom), $urandom, SKIP_CMD, 8'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom));
    push_cmd(8'($urandom), $urandom, 8'h12, 8'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom));
    drain_all();

    write_reg(REG_SBOX_LOW, {$urandom, $urandom});
    write_reg(REG_SBOX_HIGH, {$urandom, $urandom});

    // Field extremes, the skip command, sequence wrap and key offsets.
    push_cmd(8'h00, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_cmd(8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_cmd(8'h5A, 32'h8000_0001, SKIP_CMD, 8'h3C, 8'hA5, 8'h5A, 8'hC3);
    push_cmd(8'hFF, 32'hFFFF_FFFF, SKIP_CMD, 8'hFF, 8'h00, 8'hFF, 8'h00);
    push_cmd(8'h00, 32'h1234_5678, 8'hB5, 8'hFF, 8'h01, 8'h02, 8'h03);
    push_cmd(8'h0F, 32'hDEAD_BEEF, 8'hB3, 8'h00, 8'h80, 8'h7F, 8'hFE);
    push_cmd(8'hF0, 32'h0000_00FF, 8'h01, 8'h7F, 8'hFF, 8'h00, 8'hFF);
    push_cmd(8'h80, 32'hFF00_0000, 8'h80, 8'h80, 8'h55, 8'hAA, 8'h55);
    push_cmd(8'h01, 32'h00FF_FF00, 8'h7F, 8'h0F, 8'h01, 8'h80, 8'h40);
    push_cmd(8'h7F, 32'h5555_AAAA, 8'h4B, 8'h11, 8'hFF, 8'hFF, 8'h00);
    push_cmd(8'h10, 32'hAAAA_5555, 8'h48, 8'hEE, 8'h00, 8'h00, 8'hFF);
    push_cmd(8'hFE, 32'h0102_0304, 8'hFF, 8'hFE, 8'h10, 8'h20, 8'h30);
    for (int n = 0; n < 4; n++) push_random_cmd();
    drain_all();

    // Random commands under several table settings.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(REG_SBOX_LOW, '1);
          write_reg(REG_SBOX_HIGH, '1);
        end
        2: begin
          write_reg(REG_SBOX_LOW, '0);
          write_reg(REG_SBOX_HIGH, {$urandom, $urandom});
        end
        3: begin
          write_reg(REG_SBOX_LOW, {$urandom, $urandom});
          write_reg(REG_SBOX_HIGH, '0);
        end
        default: begin
          write_reg(REG_SBOX_LOW, {$urandom, $urandom});
          write_reg(REG_SBOX_HIGH, {$urandom, $urandom});
        end
      endcase
      // Writes to unused indexes must leave the table alone.
      if (p % 2 == 1) begin
        write_reg(REG_SPARE_A, {$urandom, $urandom});
        write_reg(REG_SPARE_B, {$urandom, $urandom});
      end
      gaps_enabled = (p != 2 && p != 4);
      for (int n = 0; n < 78; n++) begin
        push_random_cmd();
        // Let the frame stream run dry part way through each phase.
        if (n == 39) drain_all();
      end
      drain_all();
    end

    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
